// ===== hdl/lpmd_pkg.sv =====
// Shared types, constants and the Morse lookup for the light-pulse decoder.
// Used by lpmd_front, lpmd_queue, lpmd_back and the top level.
`timescale 1ns / 1ps

package lpmd_pkg;

  localparam int unsigned RUN_W       = 20;
  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned CODE_W      = 6;
  localparam int unsigned MAX_MARKS   = 5;
  localparam int unsigned TOTAL_W     = 3;
  localparam int unsigned CODE_COUNT  = 36;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [SAMPLE_W-1:0] LIGHT_THRESHOLD = 8'd250;
  localparam logic [RUN_W-1:0]    RUN_MAX         = {RUN_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DOT_LOW         = 3'd0,
    CFG_DOT_HIGH        = 3'd1,
    CFG_DASH_LOW        = 3'd2,
    CFG_DASH_HIGH       = 3'd3,
    CFG_LETTER_GAP_LOW  = 3'd4,
    CFG_LETTER_GAP_HIGH = 3'd5,
    CFG_WORD_GAP_LOW    = 3'd6,
    CFG_WORD_GAP_HIGH   = 3'd7
  } lpmd_cfg_idx_t;

  // One closed light/dark pair handed from front to back.
  typedef struct packed {
    logic mark_vld;
    logic mark_dash;
    logic gap_vld;
    logic gap_word;
  } lpmd_evt_t;

  typedef struct packed {
    logic              vld;
    logic [CODE_W-1:0] code;
  } lpmd_sym_t;

  typedef logic [TOTAL_W-1:0]   len_tab_t  [CODE_COUNT];
  typedef logic [MAX_MARKS-1:0] bits_tab_t [CODE_COUNT];

  localparam len_tab_t CODE_LEN = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4,
    3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4,
    3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  // Bit i set means mark i is a dash.
  localparam bits_tab_t CODE_BITS = '{
    5'd2, 5'd1, 5'd5, 5'd1, 5'd0, 5'd4, 5'd3, 5'd0, 5'd0, 5'd14, 5'd5, 5'd2,
    5'd3, 5'd1, 5'd7, 5'd6, 5'd11, 5'd2, 5'd0, 5'd1, 5'd4, 5'd8, 5'd6, 5'd9,
    5'd13, 5'd3,
    5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0, 5'd1, 5'd3, 5'd7, 5'd15
  };

  function automatic lpmd_sym_t morse_lookup(input logic [TOTAL_W-1:0]   total,
                                             input logic [MAX_MARKS-1:0] bits);
    lpmd_sym_t res;
    res = '0;
    for (int i = 0; i < CODE_COUNT; i++) begin
      if (!res.vld && CODE_LEN[i] == total && CODE_BITS[i] == bits) begin
        res.vld  = 1'b1;
        res.code = CODE_W'(i);
      end
    end
    return res;
  endfunction

endpackage

// ===== hdl/lpmd_front.sv =====
// Front end: config registers, light/dark classification and run counters.
// Emits one event per closed pair that carries a mark or a gap; uses lpmd_pkg.
`timescale 1ns / 1ps

module lpmd_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lpmd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [lpmd_pkg::RUN_W-1:0]     cfg_wdata,
  input  logic                           smp_vld,
  input  logic [lpmd_pkg::SAMPLE_W-1:0]  smp,
  output logic                           evt_push,
  output lpmd_pkg::lpmd_evt_t            evt
);
  import lpmd_pkg::*;

  logic [RUN_W-1:0] dot_low_r, dot_high_r, dash_low_r, dash_high_r;
  logic [RUN_W-1:0] letter_low_r, letter_high_r, word_low_r, word_high_r;

  logic             dark_r,      dark_nxt;
  logic [RUN_W-1:0] light_run_r, light_run_nxt;
  logic [RUN_W-1:0] dark_run_r,  dark_run_nxt;

  logic light, is_dot, is_dash, is_letter, is_word;

  function automatic logic in_win(input logic [RUN_W-1:0] v,
                                  input logic [RUN_W-1:0] lo,
                                  input logic [RUN_W-1:0] hi);
    return (v > lo) && (v < hi);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_low_r     <= RUN_W'(20000);
      dot_high_r    <= RUN_W'(30000);
      dash_low_r    <= RUN_W'(70000);
      dash_high_r   <= RUN_W'(80000);
      letter_low_r  <= RUN_W'(100000);
      letter_high_r <= RUN_W'(110000);
      word_low_r    <= RUN_W'(270000);
      word_high_r   <= RUN_W'(300000);
    end else if (cfg_we) begin
      unique case (lpmd_cfg_idx_t'(cfg_idx))
        CFG_DOT_LOW:         dot_low_r     <= cfg_wdata;
        CFG_DOT_HIGH:        dot_high_r    <= cfg_wdata;
        CFG_DASH_LOW:        dash_low_r    <= cfg_wdata;
        CFG_DASH_HIGH:       dash_high_r   <= cfg_wdata;
        CFG_LETTER_GAP_LOW:  letter_low_r  <= cfg_wdata;
        CFG_LETTER_GAP_HIGH: letter_high_r <= cfg_wdata;
        CFG_WORD_GAP_LOW:    word_low_r    <= cfg_wdata;
        CFG_WORD_GAP_HIGH:   word_high_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    light     = smp < LIGHT_THRESHOLD;
    is_dot    = in_win(light_run_r, dot_low_r, dot_high_r);
    is_dash   = !is_dot && in_win(light_run_r, dash_low_r, dash_high_r);
    is_letter = in_win(dark_run_r, letter_low_r, letter_high_r);
    is_word   = !is_letter && in_win(dark_run_r, word_low_r, word_high_r);

    dark_nxt      = dark_r;
    light_run_nxt = light_run_r;
    dark_run_nxt  = dark_run_r;
    evt_push      = 1'b0;
    evt.mark_vld  = is_dot || is_dash;
    evt.mark_dash = is_dash;
    evt.gap_vld   = is_letter || is_word;
    evt.gap_word  = is_word;

    if (smp_vld) begin
      priority if (!light) begin
        dark_nxt     = 1'b1;
        dark_run_nxt = (dark_run_r == RUN_MAX) ? RUN_MAX : dark_run_r + 1'b1;
      end else if (!dark_r) begin
        light_run_nxt = (light_run_r == RUN_MAX) ? RUN_MAX : light_run_r + 1'b1;
      end else begin
        evt_push      = evt.mark_vld || evt.gap_vld;
        dark_nxt      = 1'b0;
        light_run_nxt = RUN_W'(1);
        dark_run_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_r      <= 1'b0;
      light_run_r <= '0;
      dark_run_r  <= '0;
    end else begin
      dark_r      <= dark_nxt;
      light_run_r <= light_run_nxt;
      dark_run_r  <= dark_run_nxt;
    end
  end

endmodule

// ===== hdl/lpmd_queue.sv =====
// Short event queue between front and back ends.
// Holds lpmd_pkg::lpmd_evt_t entries; depth from lpmd_pkg.
`timescale 1ns / 1ps

module lpmd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lpmd_pkg::lpmd_evt_t push_evt,
  input  logic                pop,
  output logic                not_full,
  output logic                not_empty,
  output lpmd_pkg::lpmd_evt_t head
);
  import lpmd_pkg::*;

  lpmd_evt_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign not_full  = count_r != QCNT_W'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/lpmd_back.sv =====
// Back end: mark buffer, Morse decode and the registered result stage.
// Pops events from lpmd_queue; lookup table from lpmd_pkg.
`timescale 1ns / 1ps

module lpmd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        evt_vld,
  input  lpmd_pkg::lpmd_evt_t         evt,
  output logic                        evt_pop,
  output logic                        out_vld,
  input  logic                        out_rdy,
  output logic                        sym_vld,
  output logic [lpmd_pkg::CODE_W-1:0] sym_code,
  output logic                        sym_word
);
  import lpmd_pkg::*;

  logic [MAX_MARKS-1:0] bits_r,  bits_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic                 out_vld_r;
  logic                 sym_vld_r;
  logic [CODE_W-1:0]    sym_code_r;
  logic                 sym_word_r;
  logic                 out_free, emit;
  lpmd_sym_t            sym;

  always_comb begin
    out_free  = !out_vld_r || out_rdy;
    evt_pop   = evt_vld && (!evt.gap_vld || out_free);
    emit      = evt_pop && evt.gap_vld;
    bits_nxt  = bits_r;
    total_nxt = total_r;
    if (evt.mark_vld && total_r < TOTAL_W'(MAX_MARKS)) begin
      bits_nxt[total_r] = evt.mark_dash;
      total_nxt         = total_r + 1'b1;
    end
    sym = morse_lookup(total_nxt, bits_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r  <= '0;
      total_r <= '0;
    end else if (evt_pop) begin
      if (evt.gap_vld) begin
        bits_r  <= '0;
        total_r <= '0;
      end else begin
        bits_r  <= bits_nxt;
        total_r <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit) begin
      out_vld_r <= 1'b1;
    end else if (out_rdy) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      sym_vld_r  <= sym.vld;
      sym_code_r <= sym.vld ? sym.code : '0;
      sym_word_r <= evt.gap_word;
    end
  end

  assign out_vld  = out_vld_r;
  assign sym_vld  = sym_vld_r;
  assign sym_code = sym_code_r;
  assign sym_word = sym_word_r;

endmodule

// ===== hdl/light_pulse_morse_decoder.sv =====
// Top level of the light-pulse Morse decoder: front end, event queue, back end.
// Depends on lpmd_pkg, lpmd_front, lpmd_queue and lpmd_back.
`timescale 1ns / 1ps

// One light-sensor sample is taken per cycle; in_tready stays high unless the
// two-entry event queue fills, which happens only while a result waits at the
// output. A sample below 250 is light, anything else is dark. Marks and gaps
// are classified against the eight window registers, to be written by the user
// over cfg_* only while idle; the block does not enforce this. The light sample
// closing a letter or word gap queues an event; the back end pops it once its
// result register is free and registers the decoded result. out_tuser is 1 for
// a recognized character, out_tdata holds its code (0-25 A-Z, 26-35 digits
// 0-9, 0 when not recognized) and out_tlast flags a word gap.
module light_pulse_morse_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lpmd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [lpmd_pkg::RUN_W-1:0]     cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] light_sample
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [5:0] symbol_code, [7:6] zero
  output logic                           out_tuser,  // [0] symbol_valid
  output logic                           out_tlast   // word_end
);
  import lpmd_pkg::*;

  logic              evt_push, q_not_full, q_not_empty, evt_pop;
  lpmd_evt_t         evt_in, evt_head;
  logic [CODE_W-1:0] sym_code;

  assign in_tready = q_not_full;

  lpmd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .smp_vld   (in_tvalid && in_tready),
    .smp       (in_tdata),
    .evt_push  (evt_push),
    .evt       (evt_in)
  );

  lpmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (evt_push),
    .push_evt  (evt_in),
    .pop       (evt_pop),
    .not_full  (q_not_full),
    .not_empty (q_not_empty),
    .head      (evt_head)
  );

  lpmd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .evt_vld  (q_not_empty),
    .evt      (evt_head),
    .evt_pop  (evt_pop),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .sym_vld  (out_tuser),
    .sym_code (sym_code),
    .sym_word (out_tlast)
  );

  assign out_tdata = {{(8 - CODE_W){1'b0}}, sym_code};

endmodule

// ===== hdl/lpmd_checker.sv =====
// Port-level checks for light_pulse_morse_decoder, attached by bind.
// Watches the result channel of the top level only.
`timescale 1ns / 1ps

module lpmd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= 8'd35)
    else $error("symbol code out of range");

  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tdata == 8'd0)
    else $error("unrecognized symbol carries a nonzero code");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind light_pulse_morse_decoder lpmd_checker u_lpmd_checker (.*);

// ===== dv/morse_symbol_check.sv =====
// Watches the sample, config and symbol channels of light_pulse_morse_decoder,
// predicts each decoded symbol and compares it with what the block emits.
// Depends on lpmd_pkg for the register index names and widths.
`timescale 1ns / 1ps

module morse_symbol_check (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lpmd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [lpmd_pkg::RUN_W-1:0]     cfg_wdata,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] light_sample
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [7:0]                     out_tdata,  // [5:0] symbol_code, [7:6] zero
  input  logic                           out_tuser,  // [0] symbol_valid
  input  logic                           out_tlast,  // word_end
  output int unsigned                    symbols_pending,
  output int unsigned                    mismatch_cnt
);
  import lpmd_pkg::*;

  localparam logic [7:0]       DARK_FLOOR = 8'd250;
  localparam logic [RUN_W-1:0] RUN_FULL   = {RUN_W{1'b1}};
  localparam int               MARK_LIMIT = 5;

  typedef struct packed {
    logic       known;
    logic [5:0] code;
    logic       word;
  } symbol_t;

  symbol_t          symbols_due[$];
  logic [RUN_W-1:0] win [8];
  logic             dark_now;
  logic [RUN_W-1:0] lit_len;
  logic [RUN_W-1:0] dark_len;
  logic [4:0]       dash_mask;
  logic [2:0]       mark_cnt;
  int unsigned      err_cnt = 0;

  function automatic bit in_win(input logic [RUN_W-1:0] v, lo, hi);
    return v > lo && v < hi;
  endfunction

  // Bit i of mask set means mark i is a dash.
  function automatic symbol_t morse_symbol(input logic [2:0] cnt, input logic [4:0] mask);
    symbol_t s;
    int      code;
    case ({cnt, mask})
      {3'd2, 5'd2}:  code = 0;  {3'd4, 5'd1}:  code = 1;  {3'd4, 5'd5}:  code = 2;
      {3'd3, 5'd1}:  code = 3;  {3'd1, 5'd0}:  code = 4;  {3'd4, 5'd4}:  code = 5;
      {3'd3, 5'd3}:  code = 6;  {3'd4, 5'd0}:  code = 7;  {3'd2, 5'd0}:  code = 8;
      {3'd4, 5'd14}: code = 9;  {3'd3, 5'd5}:  code = 10; {3'd4, 5'd2}:  code = 11;
      {3'd2, 5'd3}:  code = 12; {3'd2, 5'd1}:  code = 13; {3'd3, 5'd7}:  code = 14;
      {3'd4, 5'd6}:  code = 15; {3'd4, 5'd11}: code = 16; {3'd3, 5'd2}:  code = 17;
      {3'd3, 5'd0}:  code = 18; {3'd1, 5'd1}:  code = 19; {3'd3, 5'd4}:  code = 20;
      {3'd4, 5'd8}:  code = 21; {3'd3, 5'd6}:  code = 22; {3'd4, 5'd9}:  code = 23;
      {3'd4, 5'd13}: code = 24; {3'd4, 5'd3}:  code = 25; {3'd5, 5'd31}: code = 26;
      {3'd5, 5'd30}: code = 27; {3'd5, 5'd28}: code = 28; {3'd5, 5'd24}: code = 29;
      {3'd5, 5'd16}: code = 30; {3'd5, 5'd0}:  code = 31; {3'd5, 5'd1}:  code = 32;
      {3'd5, 5'd3}:  code = 33; {3'd5, 5'd7}:  code = 34; {3'd5, 5'd15}: code = 35;
      default:       code = -1;
    endcase
    s.known = code >= 0;
    s.code  = s.known ? code[5:0] : 6'd0;
    s.word  = 1'b0;
    return s;
  endfunction

  task automatic take_sample(input logic [7:0] smp);
    symbol_t s;
    logic    mark_ok;
    logic    mark_dash;
    logic    gap_letter;
    logic    gap_word;
    if (smp >= DARK_FLOOR) begin
      dark_now = 1'b1;
      if (dark_len != RUN_FULL) dark_len = dark_len + 1'b1;
    end else if (!dark_now) begin
      if (lit_len != RUN_FULL) lit_len = lit_len + 1'b1;
    end else begin
      // close the light/dark pair; the dot window wins over the dash window
      mark_ok   = 1'b1;
      mark_dash = 1'b0;
      if (in_win(lit_len, win[CFG_DOT_LOW], win[CFG_DOT_HIGH])) mark_dash = 1'b0;
      else if (in_win(lit_len, win[CFG_DASH_LOW], win[CFG_DASH_HIGH])) mark_dash = 1'b1;
      else mark_ok = 1'b0;
      if (mark_ok && mark_cnt < MARK_LIMIT) begin
        dash_mask[mark_cnt] = mark_dash;
        mark_cnt = mark_cnt + 1'b1;
      end
      gap_letter = in_win(dark_len, win[CFG_LETTER_GAP_LOW], win[CFG_LETTER_GAP_HIGH]);
      gap_word   = !gap_letter &&
                   in_win(dark_len, win[CFG_WORD_GAP_LOW], win[CFG_WORD_GAP_HIGH]);
      if (gap_letter || gap_word) begin
        s      = morse_symbol(mark_cnt, dash_mask);
        s.word = gap_word;
        symbols_due.push_back(s);
        dash_mask = '0;
        mark_cnt  = '0;
      end
      dark_now = 1'b0;
      lit_len  = RUN_W'(1);
      dark_len = '0;
    end
  endtask

  always @(posedge clk) begin
    symbol_t want;
    if (!rst_n) begin
      win[CFG_DOT_LOW]         = 20'd20000;
      win[CFG_DOT_HIGH]        = 20'd30000;
      win[CFG_DASH_LOW]        = 20'd70000;
      win[CFG_DASH_HIGH]       = 20'd80000;
      win[CFG_LETTER_GAP_LOW]  = 20'd100000;
      win[CFG_LETTER_GAP_HIGH] = 20'd110000;
      win[CFG_WORD_GAP_LOW]    = 20'd270000;
      win[CFG_WORD_GAP_HIGH]   = 20'd300000;
      dark_now  = 1'b0;
      lit_len   = '0;
      dark_len  = '0;
      dash_mask = '0;
      mark_cnt  = '0;
      symbols_due.delete();
    end else begin
      if (out_tvalid === 1'b1 && out_tready) begin
        if (symbols_due.size() == 0) begin
          err_cnt++;
          $display("%0t ns: expected no symbol, got valid=%0b data=0x%02h word=%0b",
                   $time, out_tuser, out_tdata, out_tlast);
        end else begin
          want = symbols_due.pop_front();
          if (out_tuser !== want.known || out_tdata !== {2'b00, want.code} ||
              out_tlast !== want.word) begin
            err_cnt++;
            $display("%0t ns: expected valid=%0b data=0x%02h word=%0b,",
                     $time, want.known, {2'b00, want.code}, want.word,
                     " got valid=%0b data=0x%02h word=%0b",
                     out_tuser, out_tdata, out_tlast);
          end
        end
      end
      if (cfg_we) win[cfg_idx] = cfg_wdata;
      if (in_tvalid && in_tready) take_sample(in_tdata);
    end
    symbols_pending <= symbols_due.size();
    mismatch_cnt    <= err_cnt;
  end

endmodule

// ===== dv/tb.sv =====
// Top of the light_pulse_morse_decoder testbench: clock, reset, window setup
// and light/dark sample runs with random idling. Depends on lpmd_pkg, the
// block itself and morse_symbol_check, which predicts and compares symbols.
`timescale 1ns / 1ps

module tb;
  import lpmd_pkg::*;

  localparam int ITEMS_GOAL   = 1550;
  localparam int SETTLE       = 6;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int DARK_FLOOR   = 250;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [RUN_W-1:0]     cfg_wdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;   // [7:0] light_sample
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;       // [5:0] symbol_code, [7:6] zero
  logic                 out_tuser;       // [0] symbol_valid
  logic                 out_tlast;       // word_end
  int unsigned          symbols_pending;
  int unsigned          mismatch_cnt;

  logic [RUN_W-1:0] plan [8];
  int               idle_pct = 30;
  int               stall_pct = 30;
  int               samples_sent = 0;
  int               cycle_cnt = 0;
  int               phase;

  light_pulse_morse_decoder i_dut (.*);
  morse_symbol_check        i_check (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_sample(input logic [7:0] smp);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    do @(posedge clk); while (in_tready !== 1'b1);
    samples_sent++;
  endtask

  task automatic send_run(input bit dark, input int n);
    repeat (n) begin
      if (dark) send_sample(8'($urandom_range(DARK_FLOOR, 255)));
      else send_sample(8'($urandom_range(0, DARK_FLOOR - 1)));
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (symbols_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_plan();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_IDX_W'(i);
      cfg_wdata <= plan[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic set_windows(input int dl, dh, hl, hh, ll, lh, wl, wh);
    plan[CFG_DOT_LOW]         = RUN_W'(dl);
    plan[CFG_DOT_HIGH]        = RUN_W'(dh);
    plan[CFG_DASH_LOW]        = RUN_W'(hl);
    plan[CFG_DASH_HIGH]       = RUN_W'(hh);
    plan[CFG_LETTER_GAP_LOW]  = RUN_W'(ll);
    plan[CFG_LETTER_GAP_HIGH] = RUN_W'(lh);
    plan[CFG_WORD_GAP_LOW]    = RUN_W'(wl);
    plan[CFG_WORD_GAP_HIGH]   = RUN_W'(wh);
  endtask

  // small windows, overlapping now and then, sometimes one left empty
  task automatic plan_random();
    int dl, dh, hl, ll, lh, wl, k;
    dl = $urandom_range(0, 3);
    dh = dl + $urandom_range(2, 6);
    hl = $urandom_range(dl, dh + 3);
    ll = $urandom_range(1, 4);
    lh = ll + $urandom_range(2, 5);
    wl = $urandom_range(ll, lh + 4);
    set_windows(dl, dh, hl, hl + $urandom_range(2, 6), ll, lh, wl, wl + $urandom_range(2, 8));
    if ($urandom_range(0, 7) == 0) begin
      k = 2 * $urandom_range(0, 3);
      plan[k + 1] = RUN_W'($urandom_range(0, int'(plan[k]) + 1));
    end
  endtask

  function automatic bit hits(input int n, input logic [RUN_W-1:0] lo, hi);
    return n > int'(lo) && n < int'(hi);
  endfunction

  function automatic int pick_len(input logic [RUN_W-1:0] lo, hi);
    int span;
    span = int'(hi) - int'(lo) - 1;
    if (span < 1) return $urandom_range(1, 6);
    if (span > 8) span = 8;
    return int'(lo) + 1 + $urandom_range(0, span - 1);
  endfunction

  // dark run between marks of one letter: outside both gap windows if possible
  function automatic int gap_len();
    for (int n = 1; n <= 12; n++) begin
      if (!hits(n, plan[CFG_LETTER_GAP_LOW], plan[CFG_LETTER_GAP_HIGH]) &&
          !hits(n, plan[CFG_WORD_GAP_LOW], plan[CFG_WORD_GAP_HIGH]))
        return n;
    end
    return 1;
  endfunction

  task automatic send_letter();
    int marks;
    int len;
    if ($urandom_range(0, 9) == 0) send_run($urandom_range(0, 1), $urandom_range(1, 12));
    marks = ($urandom_range(0, 15) == 0) ? 6 : $urandom_range(1, 5);
    for (int m = 0; m < marks; m++) begin
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 12);
      else if ($urandom_range(0, 1)) len = pick_len(plan[CFG_DASH_LOW], plan[CFG_DASH_HIGH]);
      else len = pick_len(plan[CFG_DOT_LOW], plan[CFG_DOT_HIGH]);
      send_run(1'b0, len);
      if (m < marks - 1) len = gap_len();
      else if ($urandom_range(0, 3) == 0)
        len = pick_len(plan[CFG_WORD_GAP_LOW], plan[CFG_WORD_GAP_HIGH]);
      else len = pick_len(plan[CFG_LETTER_GAP_LOW], plan[CFG_LETTER_GAP_HIGH]);
      send_run(1'b1, len);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // start in dark; samples at both sides of the threshold, reset windows
    send_sample(8'd255);
    send_sample(8'd250);
    send_sample(8'd249);
    send_sample(8'd0);
    drain();

    // dot and dash windows overlap at 2, letter and word windows at 3
    set_windows(0, 3, 1, 4, 1, 4, 2, 6);
    write_plan();
    send_run(1'b0, 1); send_run(1'b1, 1);
    send_run(1'b0, 3); send_run(1'b1, 2);
    send_run(1'b0, 2); send_run(1'b1, 4);
    send_run(1'b0, 4); send_run(1'b1, 3);
    repeat (5) begin
      send_run(1'b0, 1);
      send_run(1'b1, 1);
    end
    send_run(1'b0, 1); send_run(1'b1, 5);

    samples_sent = 0;
    phase = 0;
    while (samples_sent < ITEMS_GOAL) begin
      drain();
      if (phase == 0) set_windows(0, 1048575, 0, 1048575, 0, 1048575, 0, 1048575);
      else if (phase == 1) set_windows(1048575, 0, 1048575, 0, 1048575, 0, 1048575, 0);
      else plan_random();
      idle_pct  = (phase == 0) ? 0 : 30;
      stall_pct = (phase == 0) ? 0 : 30;
      write_plan();
      repeat ((phase == 0) ? 30 : $urandom_range(2, 6)) send_letter();
      phase++;
    end
    send_run(1'b0, 1);
    drain();

    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
